@@ src/kvi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kvi_pkg;

	localparam int KEYS   = 64;
	localparam int KEY_AW = $clog2(KEYS);
	localparam int CNT_W  = 7;
	localparam int TIME_W = 32;
	localparam int VAL_W  = 32;
	localparam int FRAC_W = 16;
	localparam int STEP_W = $clog2(FRAC_W);
	localparam int IDX_W  = 6;
	localparam int SEG_W  = 6;
	localparam int KEY_W  = TIME_W + 3 * VAL_W;
	localparam int PROD_W = VAL_W + 1 + FRAC_W + 1;

	// s_tdata field offsets, lowest first
	localparam int IDX_LSB   = 0;
	localparam int KTIME_LSB = IDX_LSB + IDX_W;
	localparam int VX_LSB    = KTIME_LSB + TIME_W;
	localparam int VY_LSB    = VX_LSB + VAL_W;
	localparam int VZ_LSB    = VY_LSB + VAL_W;
	localparam int QTIME_LSB = VZ_LSB + VAL_W;
	localparam int IN_BITS   = QTIME_LSB + TIME_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

	// m_tdata field offsets
	localparam int OX_LSB     = 0;
	localparam int OY_LSB     = OX_LSB + VAL_W;
	localparam int OZ_LSB     = OY_LSB + VAL_W;
	localparam int SEG_LSB    = OZ_LSB + VAL_W;
	localparam int OUT_BITS   = SEG_LSB + SEG_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] COMP_X = 2'd0;
	localparam logic [1:0] COMP_Z = 2'd2;

	typedef struct packed {
		logic              key_wr;
		logic              query_ld;
		logic              rd_en;
		logic [KEY_AW-1:0] rd_addr;
		logic              take_prev;
		logic              take_end;
		logic              seg_ld;
		logic [KEY_AW-1:0] seg;
		logic              found_ld;
		logic              found;
		logic              div_init;
		logic              div_step;
		logic              mul_en;
		logic              add_en;
		logic [1:0]        comp;
		logic              out_ld;
	} kvi_cmd_t;

	typedef struct packed {
		logic [KEY_AW-1:0] last_idx;
		logic              q_lt;
		logic              out_free;
	} kvi_sts_t;

endpackage

`default_nettype wire

@@ src/kvi_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kvi_datapath
	import kvi_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CNT_W-1:0]      cfg_wdata,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire kvi_cmd_t              cmd,
	output kvi_sts_t                   sts,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	logic [KEY_W-1:0]          key_mem_q [KEYS];
	logic [KEY_W-1:0]          rdata_q;
	logic [CNT_W-1:0]          key_count_q;
	logic [CNT_W-1:0]          n_eff;
	logic [IDX_W-1:0]          wr_idx;
	logic [TIME_W-1:0]         query_q;
	logic [TIME_W-1:0]         prev_t_q;
	logic [TIME_W-1:0]         end_t_q;
	logic [2:0][VAL_W-1:0]     prev_v_q;
	logic [2:0][VAL_W-1:0]     end_v_q;
	logic [2:0][VAL_W-1:0]     res_q;
	logic [KEY_AW-1:0]         seg_q;
	logic                      found_q;
	logic [TIME_W-1:0]         rem_q;
	logic [TIME_W-1:0]         den_q;
	logic [FRAC_W-1:0]         quo_q;
	logic                      div_ok_q;
	logic [TIME_W:0]           rem_sh;
	logic [FRAC_W-1:0]         frac;
	logic signed [VAL_W:0]     diff;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [PROD_W-1:0]  sum;
	logic                      m_tvalid_q;
	logic [OUT_DATA_W-1:0]     m_tdata_q;

	assign wr_idx = s_tdata[IDX_LSB +: IDX_W];

	always_ff @(posedge clk) begin
		if (cmd.key_wr && (32'(wr_idx) < KEYS)) begin
			key_mem_q[KEY_AW'(wr_idx)] <= {s_tdata[VZ_LSB +: VAL_W], s_tdata[VY_LSB +: VAL_W],
				s_tdata[VX_LSB +: VAL_W], s_tdata[KTIME_LSB +: TIME_W]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= key_mem_q[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= CNT_W'(1);
		end else if (cfg_we) begin
			key_count_q <= cfg_wdata;
		end
	end

	// count of zero acts as one, above the table size as the table size
	always_comb begin
		priority if (key_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (32'(key_count_q) > KEYS) begin
			n_eff = CNT_W'(KEYS);
		end else begin
			n_eff = key_count_q;
		end
	end

	assign sts.last_idx = KEY_AW'(n_eff - CNT_W'(1));
	assign sts.q_lt     = query_q < rdata_q[TIME_W-1:0];
	assign sts.out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.query_ld) begin
			query_q <= s_tdata[QTIME_LSB +: TIME_W];
		end
		if (cmd.take_prev) begin
			prev_t_q <= rdata_q[TIME_W-1:0];
			prev_v_q <= rdata_q[KEY_W-1:TIME_W];
		end
		if (cmd.take_end) begin
			end_t_q <= rdata_q[TIME_W-1:0];
			end_v_q <= rdata_q[KEY_W-1:TIME_W];
		end
		if (cmd.seg_ld) begin
			seg_q <= cmd.seg;
		end
		if (cmd.found_ld) begin
			found_q <= cmd.found;
		end
	end

	// restoring division, one quotient bit per step; remainder stays below den
	assign rem_sh = {rem_q, 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q    <= query_q - prev_t_q;
			den_q    <= end_t_q - prev_t_q;
			quo_q    <= '0;
			div_ok_q <= (query_q > prev_t_q) && (end_t_q > prev_t_q);
		end else if (cmd.div_step) begin
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= TIME_W'(rem_sh - {1'b0, den_q});
				quo_q <= {quo_q[FRAC_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[TIME_W-1:0];
				quo_q <= {quo_q[FRAC_W-2:0], 1'b0};
			end
		end
	end

	assign frac = div_ok_q ? quo_q : '0;
	assign diff = $signed({end_v_q[cmd.comp][VAL_W-1], end_v_q[cmd.comp]})
		- $signed({prev_v_q[cmd.comp][VAL_W-1], prev_v_q[cmd.comp]});
	assign sum  = PROD_W'($signed(prev_v_q[cmd.comp])) + (prod_s1 >>> FRAC_W);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= PROD_W'(diff * $signed({1'b0, frac}));
		end
		if (cmd.add_en) begin
			res_q[cmd.comp] <= sum[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			m_tdata_q <= OUT_DATA_W'({SEG_W'(seg_q), found_q ? res_q : prev_v_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

@@ src/kvi_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kvi_ctrl
	import kvi_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  wire logic     s_tuser,
	input  wire kvi_sts_t sts,
	output kvi_cmd_t      cmd
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_RD   = 8'b0000_0010,
		ST_CMP  = 8'b0000_0100,
		ST_DIVI = 8'b0000_1000,
		ST_DIV  = 8'b0001_0000,
		ST_MUL  = 8'b0010_0000,
		ST_ADD  = 8'b0100_0000,
		ST_OUT  = 8'b1000_0000
	} kvi_state_t;

	kvi_state_t        state_q, state_d;
	logic [KEY_AW-1:0] idx_q, idx_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [1:0]        comp_q, comp_d;
	logic              accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		step_d  = step_q;
		comp_d  = comp_q;
		cmd     = '0;
		cmd.rd_addr = idx_q;
		cmd.comp    = comp_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == OP_QUERY) begin
						cmd.query_ld = 1'b1;
						idx_d   = '0;
						state_d = ST_RD;
					end else begin
						cmd.key_wr = 1'b1;
					end
				end
			end
			ST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_CMP;
			end
			ST_CMP: begin
				// key 0 only primes the start registers
				if (idx_q != '0 && sts.q_lt) begin
					cmd.take_end = 1'b1;
					cmd.seg_ld   = 1'b1;
					cmd.seg      = idx_q - KEY_AW'(1);
					cmd.found_ld = 1'b1;
					cmd.found    = 1'b1;
					state_d      = ST_DIVI;
				end else begin
					cmd.take_prev = 1'b1;
					if (idx_q == sts.last_idx) begin
						cmd.seg_ld   = 1'b1;
						cmd.seg      = idx_q;
						cmd.found_ld = 1'b1;
						cmd.found    = 1'b0;
						state_d      = ST_OUT;
					end else begin
						idx_d   = idx_q + KEY_AW'(1);
						state_d = ST_RD;
					end
				end
			end
			ST_DIVI: begin
				cmd.div_init = 1'b1;
				step_d  = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				step_d = step_q + STEP_W'(1);
				if (step_q == STEP_W'(FRAC_W - 1)) begin
					comp_d  = COMP_X;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_ADD;
			end
			ST_ADD: begin
				cmd.add_en = 1'b1;
				if (comp_q == COMP_Z) begin
					state_d = ST_OUT;
				end else begin
					comp_d  = comp_q + 2'd1;
					state_d = ST_MUL;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			step_q  <= '0;
			comp_q  <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			step_q  <= step_d;
			comp_q  <= comp_d;
		end
	end

endmodule

`default_nettype wire

@@ src/keyframe_vector_interpolator_core.sv @@
// channel   dir  signals                          item
// s         in   s_tvalid s_tready s_tdata s_tuser key write (s_tuser 0) or query (s_tuser 1)
// m         out  m_tvalid m_tready m_tdata         interpolated vector and segment
// cfg       in   cfg_we cfg_wdata                  key_count register
//
// a key write is taken in the idle state and leaves the input ready. a query is accepted, then
// scans the key table through one memory read port, with a read state and a compare state per
// key up to the matching key k, then goes straight to output for a single key or a query past
// the last key, or interpolates (setup, 16 division steps, three multiply-add rounds, output).
// reset clears the controller, the output valid and sets key_count to 1; no key table reset.
// a query waits at its end only while a result is held.
`timescale 1ns / 1ps
`default_nettype none

module keyframe_vector_interpolator_core
	import kvi_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CNT_W-1:0]      cfg_wdata,  // key_count
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// key_index, key_time, val_x, val_y, val_z, query_time, zero pad
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  s_tuser,    // op
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// out_x, out_y, out_z, segment, zero pad
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	kvi_cmd_t cmd;
	kvi_sts_t sts;

	kvi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	kvi_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire

@@ src/kvi_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kvi_checker
	import kvi_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic                  s_tuser,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata
);

	// held result keeps its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a query occupies the block
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_QUERY) |=> !s_tready)
		else $error("input taken during a query");

	// a key write finishes in its own cycle
	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_WRITE) |=> s_tready)
		else $error("key write stalled the input");

	// a new result only appears as a query ends
	a_result_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result raised while busy");

endmodule

bind keyframe_vector_interpolator_core kvi_checker u_kvi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
